// File: sv/uctmr_pkg.sv
// Shared constants and types of the up-counting prescaled timer.
`default_nettype none

package uctmr_pkg;

  // Field widths of the bus and the timer registers
  localparam int ACTION_W = 2;
  localparam int OFS_W    = 6;
  localparam int DATA_W   = 32;
  localparam int CNT_W    = 32;
  localparam int PSC_W    = 16;

  // Kinds of input beat
  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  // Register byte offsets
  localparam logic [OFS_W-1:0] OFS_CONTROL  = 6'h00;
  localparam logic [OFS_W-1:0] OFS_STATUS   = 6'h10;
  localparam logic [OFS_W-1:0] OFS_EVENT    = 6'h14;
  localparam logic [OFS_W-1:0] OFS_COUNT    = 6'h24;
  localparam logic [OFS_W-1:0] OFS_PRESCALE = 6'h28;
  localparam logic [OFS_W-1:0] OFS_RELOAD   = 6'h2C;

  // Control register bit positions
  localparam int CTRL_ENABLE_BIT  = 0;
  localparam int CTRL_PRELOAD_BIT = 7;

endpackage : uctmr_pkg

`default_nettype wire

// File: sv/uctmr_if.sv
// Valid/ready channel interfaces for timer requests and results.
`default_nettype none

interface uctmr_in_if
  import uctmr_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [OFS_W-1:0]    reg_offset;
  logic [DATA_W-1:0]   write_data;

  modport source (output valid, output action, output reg_offset, output write_data,
                  input ready);
  modport sink   (input valid, input action, input reg_offset, input write_data,
                  output ready);
endinterface : uctmr_in_if

interface uctmr_out_if
  import uctmr_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic              update_flag;

  modport source (output valid, output read_data, output update_flag, input ready);
  modport sink   (input valid, input read_data, input update_flag, output ready);
endinterface : uctmr_out_if

`default_nettype wire

// File: sv/upcount_timer_prescale_reload.sv
// Up-counting timer with prescaler and auto-reload behind a small register bus.
//
// Usage:
//   in_ch carries one beat per timer tick, bus write or bus read (action,
//   reg_offset, write_data). out_ch returns exactly one beat per input beat:
//   read_data (register value on a read, else 0) and update_flag (the update
//   flag after that beat), in input order.
//   Path: an accepted beat goes through the input register, then the timer
//   update into the result register, which drives out_ch.
//   Throughput: one beat per cycle; the whole timer step is a single pass of
//   short logic, so in_ch takes a beat every cycle while out_ch keeps up.
//   Stall: when out_ch.ready is low the result register holds and the input
//   register still takes one more beat; after that in_ch.ready drops until
//   the result is taken. Timer state moves only when a beat moves forward.
//   Reset (rst_n low, synchronous): both pipeline registers empty, counters
//   and prescaler 0, reload values all ones, control and update flag clear.
`default_nettype none

module upcount_timer_prescale_reload
  import uctmr_pkg::*;
(
  input  wire               clk,
  input  wire               rst_n,
  uctmr_in_if.sink          in_ch,
  uctmr_out_if.source       out_ch
);

  // Input register
  logic                in_valid_r;
  action_t             in_action_r;
  logic [OFS_W-1:0]    in_ofs_r;
  logic [DATA_W-1:0]   in_wdata_r;

  // Result register
  logic                out_valid_r;
  logic [DATA_W-1:0]   out_rdata_r;
  logic                out_flag_r;

  // Timer state
  logic                en_r,       en_nxt;
  logic                arpe_r,     arpe_nxt;
  logic [PSC_W-1:0]    psc_wr_r,   psc_wr_nxt;
  logic [PSC_W-1:0]    psc_act_r,  psc_act_nxt;
  logic [PSC_W-1:0]    psc_cnt_r,  psc_cnt_nxt;
  logic [CNT_W-1:0]    arr_wr_r,   arr_wr_nxt;
  logic [CNT_W-1:0]    arr_act_r,  arr_act_nxt;
  logic [CNT_W-1:0]    cnt_r,      cnt_nxt;
  logic                flag_r,     flag_nxt;
  logic [DATA_W-1:0]   rdata_nxt;

  logic                out_free;
  logic                adv;

  // Pipeline handshake
  assign out_free    = !out_valid_r || out_ch.ready;
  assign adv         = in_valid_r && out_free;
  assign in_ch.ready = !in_valid_r || out_free;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.read_data   = out_rdata_r;
  assign out_ch.update_flag = out_flag_r;

  // Capture input beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
    if (in_ch.valid && in_ch.ready) begin
      in_action_r <= action_t'(in_ch.action);
      in_ofs_r    <= in_ch.reg_offset;
      in_wdata_r  <= in_ch.write_data;
    end
  end

  // Timer step for the registered beat
  always_comb begin
    en_nxt      = en_r;
    arpe_nxt    = arpe_r;
    psc_wr_nxt  = psc_wr_r;
    psc_act_nxt = psc_act_r;
    psc_cnt_nxt = psc_cnt_r;
    arr_wr_nxt  = arr_wr_r;
    arr_act_nxt = arr_act_r;
    cnt_nxt     = cnt_r;
    flag_nxt    = flag_r;
    rdata_nxt   = '0;
    case (in_action_r)
      ACT_TICK: begin
        if (en_r) begin
          if (psc_cnt_r >= psc_act_r) begin
            psc_cnt_nxt = '0;
            if (cnt_r == arr_act_r) begin
              // wrap with update event
              cnt_nxt     = '0;
              flag_nxt    = 1'b1;
              psc_act_nxt = psc_wr_r;
              arr_act_nxt = arr_wr_r;
            end else begin
              cnt_nxt = cnt_r + 1'b1;
            end
          end else begin
            psc_cnt_nxt = psc_cnt_r + 1'b1;
          end
        end
      end
      ACT_WRITE: begin
        case (in_ofs_r)
          OFS_CONTROL: begin
            en_nxt   = in_wdata_r[CTRL_ENABLE_BIT];
            arpe_nxt = in_wdata_r[CTRL_PRELOAD_BIT];
          end
          OFS_STATUS: begin
            if (!in_wdata_r[0]) flag_nxt = 1'b0;
          end
          OFS_EVENT: begin
            // forced update
            if (in_wdata_r[0]) begin
              psc_cnt_nxt = '0;
              cnt_nxt     = '0;
              psc_act_nxt = psc_wr_r;
              arr_act_nxt = arr_wr_r;
              flag_nxt    = 1'b1;
            end
          end
          OFS_COUNT:    cnt_nxt    = CNT_W'(in_wdata_r);
          OFS_PRESCALE: psc_wr_nxt = PSC_W'(in_wdata_r);
          OFS_RELOAD: begin
            arr_wr_nxt = CNT_W'(in_wdata_r);
            if (!arpe_r) arr_act_nxt = CNT_W'(in_wdata_r);
          end
          default: ;
        endcase
      end
      ACT_READ: begin
        case (in_ofs_r)
          OFS_CONTROL: begin
            rdata_nxt[CTRL_ENABLE_BIT]  = en_r;
            rdata_nxt[CTRL_PRELOAD_BIT] = arpe_r;
          end
          OFS_STATUS:   rdata_nxt = DATA_W'(flag_r);
          OFS_COUNT:    rdata_nxt = DATA_W'(cnt_r);
          OFS_PRESCALE: rdata_nxt = DATA_W'(psc_wr_r);
          OFS_RELOAD:   rdata_nxt = DATA_W'(arr_wr_r);
          default:      rdata_nxt = '0;
        endcase
      end
      default: ;
    endcase
  end

  // Commit state and result when the beat moves forward
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r        <= 1'b0;
      arpe_r      <= 1'b0;
      psc_wr_r    <= '0;
      psc_act_r   <= '0;
      psc_cnt_r   <= '0;
      arr_wr_r    <= '1;
      arr_act_r   <= '1;
      cnt_r       <= '0;
      flag_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        en_r      <= en_nxt;
        arpe_r    <= arpe_nxt;
        psc_wr_r  <= psc_wr_nxt;
        psc_act_r <= psc_act_nxt;
        psc_cnt_r <= psc_cnt_nxt;
        arr_wr_r  <= arr_wr_nxt;
        arr_act_r <= arr_act_nxt;
        cnt_r     <= cnt_nxt;
        flag_r    <= flag_nxt;
      end
      if (out_free) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (adv) begin
      out_rdata_r <= rdata_nxt;
      out_flag_r  <= flag_nxt;
    end
  end

`ifndef SYNTHESIS
  // prescaler never runs past its active limit
  a_psc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    psc_cnt_r <= psc_act_r)
    else $error("prescaler counter above active prescale");

  // a beat that moves forward shows up in the result register
  a_adv_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r)
    else $error("advanced beat lost");

  // update flag rises only from a processed beat
  a_flag_src: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $rose(flag_r) |-> $past(adv))
    else $error("update flag set without a beat");

  // counter holds while no beat moves forward
  a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$past(adv) |-> $stable(cnt_r))
    else $error("counter changed without a beat");

  // result flag mirrors the timer flag after each processed beat
  a_flag_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_flag_r == flag_r)
    else $error("result flag differs from timer flag");
`endif

endmodule : upcount_timer_prescale_reload

`default_nettype wire
